// File: hw/rtl/cse_pkg.sv
// Shared types, constants and fixed-point helpers for the Chebyshev series evaluator.
`default_nettype none

package cse_pkg;

   localparam int DATA_WIDTH         = 32;
   localparam int FRAC_BITS          = 24;
   localparam int IDX_WIDTH          = 6;
   localparam int CSR_INDEX_WIDTH    = 2;
   localparam int DEFAULT_COEF_DEPTH = 64;
   localparam int PROD_WIDTH         = 2 * DATA_WIDTH + 1;

   typedef logic signed [DATA_WIDTH-1:0] data_type;
   typedef logic signed [PROD_WIDTH-1:0] prod_type;
   typedef logic [IDX_WIDTH-1:0]         idx_type;

   localparam data_type DATA_MAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};
   localparam data_type DATA_MIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};
   localparam data_type FIX_ONE  = data_type'(1) << FRAC_BITS;

   // half an LSB after the shift: FRAC_BITS for plain products, FRAC_BITS-1 for 2*t*b
   localparam prod_type ROUND_FULL = prod_type'(1) << (FRAC_BITS - 1);
   localparam prod_type ROUND_STEP = prod_type'(1) << (FRAC_BITS - 2);

   localparam idx_type  RESET_DEGREE = idx_type'(2);
   localparam data_type RESET_CENTER = '0;

   typedef enum logic {
      OP_LOAD = 1'b0,
      OP_EVAL = 1'b1
   } opcode_type;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_DEGREE = 2'd0,
      CSR_CENTER = 2'd1,
      CSR_INV_HW = 2'd2
   } csr_index_type;

   typedef struct packed {
      opcode_type opcode;
      idx_type    coef_index;
      data_type   coef_value;
      data_type   arg_value;
   } req_type;

   typedef struct packed {
      data_type series_value;
      logic     saturated;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_TMUL,
      ST_TRND,
      ST_MUL,
      ST_ACC,
      ST_SUB
   } state_type;

   typedef struct packed {
      logic load_write;
      logic eval_start;
      logic t_mul;
      logic t_round;
      logic step_mul;
      logic step_acc;
      logic step_sub;
      logic out_load;
   } cmd_type;

   typedef struct packed {
      logic k_zero;
      logic out_free;
   } status_type;

   typedef struct packed {
      data_type value;
      logic     ovf;
   } sat_result_type;

   function automatic sat_result_type sat_add(data_type a, data_type b);
      logic signed [DATA_WIDTH:0] sum;
      sat_result_type r;
      sum = {a[DATA_WIDTH-1], a} + {b[DATA_WIDTH-1], b};
      r.ovf = sum[DATA_WIDTH] ^ sum[DATA_WIDTH-1];
      if (r.ovf) begin
         r.value = sum[DATA_WIDTH] ? DATA_MIN : DATA_MAX;
      end else begin
         r.value = sum[DATA_WIDTH-1:0];
      end
      return r;
   endfunction

   function automatic sat_result_type sat_sub(data_type a, data_type b);
      logic signed [DATA_WIDTH:0] diff;
      sat_result_type r;
      diff = {a[DATA_WIDTH-1], a} - {b[DATA_WIDTH-1], b};
      r.ovf = diff[DATA_WIDTH] ^ diff[DATA_WIDTH-1];
      if (r.ovf) begin
         r.value = diff[DATA_WIDTH] ? DATA_MIN : DATA_MAX;
      end else begin
         r.value = diff[DATA_WIDTH-1:0];
      end
      return r;
   endfunction

   // p already holds the rounding half LSB; step selects the shift by FRAC_BITS-1
   function automatic sat_result_type round_sat(prod_type p, logic step);
      prod_type s;
      sat_result_type r;
      s = step ? (p >>> (FRAC_BITS - 1)) : (p >>> FRAC_BITS);
      if ((s[PROD_WIDTH-1:DATA_WIDTH-1] == '0) || (s[PROD_WIDTH-1:DATA_WIDTH-1] == '1)) begin
         r.value = s[DATA_WIDTH-1:0];
         r.ovf   = 1'b0;
      end else begin
         r.value = s[PROD_WIDTH-1] ? DATA_MIN : DATA_MAX;
         r.ovf   = 1'b1;
      end
      return r;
   endfunction

endpackage

`default_nettype wire

// File: hw/rtl/chebyshev_series_evaluator.sv
// Chebyshev series evaluator top level: Clenshaw sequencer plus datapath.
// Load transfers are accepted back to back while idle.
// Evaluate: the input stays stalled until the result is loaded into the output register,
// which waits while an earlier result is held by rsp_stall; then the next item is taken.
// Each coefficient runs in turn: multiply, round/accumulate, subtract, sharing one multiplier.
// Synchronous active-high reset restores config defaults and idles; coefficients are not cleared.
`default_nettype none

module chebyshev_series_evaluator #(
   parameter int COEF_DEPTH = cse_pkg::DEFAULT_COEF_DEPTH
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output logic                                     req_stall,
   input  wire cse_pkg::req_type                    req_data,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_stall,
   output cse_pkg::rsp_type                         rsp_data,
   input  wire logic                                csr_valid,
   output logic                                     csr_ready,
   input  wire logic [cse_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  wire cse_pkg::data_type                   csr_wdata
);

   cse_pkg::cmd_type    cmd;
   cse_pkg::status_type status;

   assign csr_ready = 1'b1;

   cse_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_opcode (req_data.opcode),
      .status     (status),
      .req_stall  (req_stall),
      .cmd        (cmd)
   );

   cse_datapath #(
      .COEF_DEPTH (COEF_DEPTH)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .csr_write (csr_valid && csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .rsp_stall (rsp_stall),
      .cmd       (cmd),
      .status    (status),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire

// File: hw/rtl/cse_ctrl.sv
// Sequencer for coefficient loads and the Clenshaw evaluation loop.
`default_nettype none

module cse_ctrl (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   input  wire cse_pkg::opcode_type req_opcode,
   input  wire cse_pkg::status_type status,
   output logic                     req_stall,
   output cse_pkg::cmd_type         cmd
);

   cse_pkg::state_type state_ff;
   cse_pkg::state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= cse_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_stall = 1'b1;
      unique case (state_ff)
         cse_pkg::ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               if (req_opcode == cse_pkg::OP_EVAL) begin
                  cmd.eval_start = 1'b1;
                  state_in       = cse_pkg::ST_TMUL;
               end else begin
                  cmd.load_write = 1'b1;
               end
            end
         end
         cse_pkg::ST_TMUL: begin
            cmd.t_mul = 1'b1;
            state_in  = cse_pkg::ST_TRND;
         end
         cse_pkg::ST_TRND: begin
            cmd.t_round = 1'b1;
            state_in    = cse_pkg::ST_MUL;
         end
         cse_pkg::ST_MUL: begin
            cmd.step_mul = 1'b1;
            state_in     = cse_pkg::ST_ACC;
         end
         cse_pkg::ST_ACC: begin
            cmd.step_acc = 1'b1;
            state_in     = cse_pkg::ST_SUB;
         end
         cse_pkg::ST_SUB: begin
            if (!status.k_zero) begin
               cmd.step_sub = 1'b1;
               state_in     = cse_pkg::ST_MUL;
            end else if (status.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = cse_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = cse_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire

// File: hw/rtl/cse_datapath.sv
// Coefficient memory, config registers, shared multiplier and saturating Clenshaw datapath.
`default_nettype none

module cse_datapath #(
   parameter int COEF_DEPTH = cse_pkg::DEFAULT_COEF_DEPTH
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire cse_pkg::req_type                      req_data,
   input  wire logic                                  csr_write,
   input  wire logic [cse_pkg::CSR_INDEX_WIDTH-1:0]   csr_index,
   input  wire cse_pkg::data_type                     csr_wdata,
   input  wire logic                                  rsp_stall,
   input  wire cse_pkg::cmd_type                      cmd,
   output cse_pkg::status_type                        status,
   output logic                                       rsp_valid,
   output cse_pkg::rsp_type                           rsp_data
);

   localparam int ADDR_WIDTH = $clog2(COEF_DEPTH);

   cse_pkg::data_type coef_mem [COEF_DEPTH];

   cse_pkg::idx_type  degree_ff, degree_in;
   cse_pkg::data_type center_ff, center_in;
   cse_pkg::data_type inv_hw_ff, inv_hw_in;

   cse_pkg::data_type d_ff, d_in;
   cse_pkg::data_type t_ff, t_in;
   cse_pkg::data_type b1_ff, b1_in;
   cse_pkg::data_type b2_ff, b2_in;
   cse_pkg::data_type s_ff, s_in;
   cse_pkg::prod_type prod_ff, prod_in;
   cse_pkg::idx_type  k_ff, k_in;
   logic              sat_ff, sat_in;
   logic              rsp_valid_ff, rsp_valid_in;
   cse_pkg::rsp_type  rsp_data_ff, rsp_data_in;
   cse_pkg::data_type coef_rd_ff;
   logic              coef_ok_ff;

   logic                           wr_ok;
   logic [ADDR_WIDTH-1:0]          wr_addr;
   logic [ADDR_WIDTH-1:0]          rd_addr;
   cse_pkg::data_type              mul_a, mul_b;
   logic signed [2*cse_pkg::DATA_WIDTH-1:0] mult;
   cse_pkg::prod_type              round_c;
   cse_pkg::data_type              coef;
   cse_pkg::sat_result_type        diff_r, rnd_r, acc_r, sub_r;

   assign wr_ok   = 32'(req_data.coef_index) < COEF_DEPTH;
   assign wr_addr = ADDR_WIDTH'(req_data.coef_index);
   assign rd_addr = ADDR_WIDTH'(k_ff);

   always_ff @(posedge clock) begin
      if (cmd.load_write && wr_ok) begin
         coef_mem[wr_addr] <= req_data.coef_value;
      end
      coef_rd_ff <= coef_mem[rd_addr];
      coef_ok_ff <= 32'(k_ff) < COEF_DEPTH;
   end

   assign status.k_zero   = (k_ff == '0);
   assign status.out_free = !rsp_valid_ff || !rsp_stall;

   assign mul_a   = cmd.t_mul ? d_ff : t_ff;
   assign mul_b   = cmd.t_mul ? inv_hw_ff : b1_ff;
   assign mult    = mul_a * mul_b;
   assign round_c = (cmd.t_mul || status.k_zero) ? cse_pkg::ROUND_FULL : cse_pkg::ROUND_STEP;
   assign coef    = coef_ok_ff ? coef_rd_ff : '0;

   assign diff_r = cse_pkg::sat_sub(req_data.arg_value, center_ff);
   assign rnd_r  = cse_pkg::round_sat(prod_ff, !cmd.t_round && !status.k_zero);
   assign acc_r  = cse_pkg::sat_add(coef, rnd_r.value);
   assign sub_r  = cse_pkg::sat_sub(s_ff, b2_ff);

   always_comb begin
      degree_in    = degree_ff;
      center_in    = center_ff;
      inv_hw_in    = inv_hw_ff;
      d_in         = d_ff;
      t_in         = t_ff;
      b1_in        = b1_ff;
      b2_in        = b2_ff;
      s_in         = s_ff;
      prod_in      = prod_ff;
      k_in         = k_ff;
      sat_in       = sat_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;

      if (csr_write) begin
         unique case (csr_index)
            cse_pkg::CSR_DEGREE: degree_in = csr_wdata[cse_pkg::IDX_WIDTH-1:0];
            cse_pkg::CSR_CENTER: center_in = csr_wdata;
            cse_pkg::CSR_INV_HW: inv_hw_in = csr_wdata;
            default: begin
            end
         endcase
      end

      if (cmd.eval_start) begin
         d_in   = diff_r.value;
         sat_in = diff_r.ovf;
         k_in   = degree_ff;
      end
      if (cmd.t_mul || cmd.step_mul) begin
         prod_in = cse_pkg::prod_type'(mult) + round_c;
      end
      if (cmd.t_round) begin
         t_in   = rnd_r.value;
         sat_in = sat_ff | rnd_r.ovf;
         b1_in  = '0;
         b2_in  = '0;
      end
      if (cmd.step_acc) begin
         s_in   = acc_r.value;
         sat_in = sat_ff | rnd_r.ovf | acc_r.ovf;
      end
      if (cmd.step_sub) begin
         b1_in  = sub_r.value;
         b2_in  = b1_ff;
         k_in   = k_ff - 1'b1;
         sat_in = sat_ff | sub_r.ovf;
      end

      if (cmd.out_load) begin
         rsp_valid_in             = 1'b1;
         rsp_data_in.series_value = sub_r.value;
         rsp_data_in.saturated    = sat_ff | sub_r.ovf;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         degree_ff    <= cse_pkg::RESET_DEGREE;
         center_ff    <= cse_pkg::RESET_CENTER;
         inv_hw_ff    <= cse_pkg::FIX_ONE;
         rsp_valid_ff <= 1'b0;
      end else begin
         degree_ff    <= degree_in;
         center_ff    <= center_in;
         inv_hw_ff    <= inv_hw_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      d_ff        <= d_in;
      t_ff        <= t_in;
      b1_ff       <= b1_in;
      b2_ff       <= b2_in;
      s_ff        <= s_in;
      prod_ff     <= prod_in;
      k_ff        <= k_in;
      sat_ff      <= sat_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

`default_nettype wire

// File: hw/rtl/cse_checker.sv
// Port-level checks for the Chebyshev series evaluator, bound to the top level.
`default_nettype none

module cse_checker (
   input wire logic                                clock,
   input wire logic                                reset,
   input wire logic                                req_valid,
   input wire logic                                req_stall,
   input wire cse_pkg::req_type                    req_data,
   input wire logic                                rsp_valid,
   input wire logic                                rsp_stall,
   input wire cse_pkg::rsp_type                    rsp_data
);

   logic eval_xfer;
   logic load_xfer;

   assign eval_xfer = req_valid && !req_stall && (req_data.opcode == cse_pkg::OP_EVAL);
   assign load_xfer = req_valid && !req_stall && (req_data.opcode == cse_pkg::OP_LOAD);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("result changed while stalled");

   a_eval_busy: assert property (@(posedge clock) disable iff (reset)
      eval_xfer |=> req_stall)
      else $error("input taken during evaluation");

   a_load_free: assert property (@(posedge clock) disable iff (reset)
      load_xfer |=> !req_stall)
      else $error("load transfer blocked the input");

   a_rsp_from_eval: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_stall))
      else $error("result appeared outside an evaluation");

endmodule

bind chebyshev_series_evaluator cse_checker u_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);

`default_nettype wire
